>>> sv/rrd_pkg.sv
package rrd_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int GROUP_SIZE  = 32;
    localparam int GROUP_SHIFT = $clog2(GROUP_SIZE);

    localparam int CNT_W = 10;
    localparam int DIST_W = 12;
    localparam int POS_W = 12;
    localparam int LEN_W = POS_W + 1;
    localparam int N_W = CNT_W + 1;
    localparam int GP_W = 5;

    localparam logic [7:0] HEAD_BYTE   = 8'h47;
    localparam logic [5:0] CHAR_OFFSET = 6'h30;
    localparam logic [LEN_W-1:0] HEADER_SKIP = 13'd11;
    localparam logic [LEN_W-1:0] REPLY_OVERHEAD = 13'd15;

    localparam logic [N_W-1:0] MAX_N = N_W'(MAX_POINTS);

    localparam logic [1:0] CFG_DISTANCE_COUNT = 2'd0;
    localparam logic [1:0] CFG_MIN_DISTANCE   = 2'd1;
    localparam logic [1:0] CFG_SYNC_LIMIT     = 2'd2;

    localparam logic [9:0]  RST_DISTANCE_COUNT = 10'd227;
    localparam logic [11:0] RST_MIN_DISTANCE   = 12'd20;
    localparam logic [11:0] RST_SYNC_LIMIT     = 12'd2000;

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_SKIP  = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;
    localparam logic [1:0] PH_TRAIL = 2'd3;

    typedef struct packed {
        logic [CNT_W-1:0]  distance_count;
        logic [DIST_W-1:0] min_distance;
        logic [POS_W-1:0]  sync_limit;
    } t_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic [CNT_W-1:0]  point_index;
        logic              last;
        logic              sync_error;
    } t_result;

endpackage

>>> sv/rrd_byte_if.sv
interface rrd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> sv/rrd_dist_if.sv
interface rrd_dist_if;
    logic        valid;
    logic        ready;
    logic [11:0] distance;
    logic [9:0]  point_index;
    logic        last;
    logic        sync_error;

    modport source (output valid, output distance, output point_index, output last,
                    output sync_error, input ready);
    modport sink (input valid, input distance, input point_index, input last,
                  input sync_error, output ready);
endinterface

>>> sv/rrd_core.sv
module rrd_core
    import rrd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_pc, n_pc;
    logic [GP_W-1:0]  r_gp, n_gp;
    logic [5:0]       r_hc, n_hc;
    logic             r_ch, n_ch;

    logic [N_W-1:0]   n_wanted;
    logic [LEN_W-1:0] reply_len;
    logic [LEN_W-1:0] pos_inc;
    logic [N_W-1:0]   pc_inc;
    logic [GP_W:0]    gp_inc;
    logic [5:0]       six;
    logic [DIST_W-1:0] dist_val;

    assign n_wanted  = ({1'b0, i_cfg.distance_count} > MAX_N) ? MAX_N
                                                              : {1'b0, i_cfg.distance_count};
    assign reply_len = REPLY_OVERHEAD + {1'b0, n_wanted, 1'b0}
                     + LEN_W'(n_wanted >> GROUP_SHIFT);
    assign pos_inc   = {1'b0, r_pos} + 1'b1;
    assign pc_inc    = {1'b0, r_pc} + 1'b1;
    assign gp_inc    = {1'b0, r_gp} + 1'b1;
    assign six       = i_rx_byte[5:0] - CHAR_OFFSET;
    assign dist_val  = ({r_hc, six} < i_cfg.min_distance) ? '0 : {r_hc, six};

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_pc        = r_pc;
        n_gp        = r_gp;
        n_hc        = r_hc;
        n_ch        = r_ch;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept) begin
            if (r_phase == PH_HUNT) begin
                if (i_rx_byte == HEAD_BYTE) begin
                    n_phase = PH_SKIP;
                    n_pos   = '0;
                    n_pc    = '0;
                    n_gp    = '0;
                    n_hc    = '0;
                    n_ch    = 1'b0;
                end else if (pos_inc >= {1'b0, i_cfg.sync_limit}) begin
                    n_pos            = '0;
                    o_res_valid      = 1'b1;
                    o_res.sync_error = 1'b1;
                end else begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end else begin
                case (r_phase)
                    PH_SKIP: begin
                        if (pos_inc >= HEADER_SKIP) begin
                            n_phase = ({1'b0, r_pc} < n_wanted) ? PH_DATA : PH_TRAIL;
                        end
                    end
                    PH_DATA: begin
                        if ({1'b0, r_pc} >= n_wanted) begin
                            n_phase = PH_TRAIL;
                        end else if (!r_ch) begin
                            n_hc = six;
                            n_ch = 1'b1;
                        end else begin
                            n_ch              = 1'b0;
                            o_res_valid       = 1'b1;
                            o_res.distance    = dist_val;
                            o_res.point_index = r_pc;
                            o_res.last        = (pc_inc == n_wanted);
                            n_pc              = pc_inc[CNT_W-1:0];
                            n_gp              = gp_inc[GP_W-1:0];
                            if (pc_inc >= n_wanted) begin
                                n_phase = PH_TRAIL;
                            end else if (gp_inc >= (GP_W+1)'(GROUP_SIZE)) begin
                                n_gp    = '0;
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                // end of reply by byte count
                if (pos_inc >= reply_len) begin
                    n_phase = PH_HUNT;
                    n_pos   = '0;
                    n_pc    = '0;
                    n_gp    = '0;
                    n_hc    = '0;
                    n_ch    = 1'b0;
                end else begin
                    n_pos = pos_inc[POS_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_pos   <= '0;
            r_pc    <= '0;
            r_gp    <= '0;
            r_hc    <= '0;
            r_ch    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_pc    <= n_pc;
            r_gp    <= n_gp;
            r_hc    <= n_hc;
            r_ch    <= n_ch;
        end
    end

`ifndef SYNTHESIS
    a_hunt_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HUNT |-> r_pc == '0 && !r_ch)
        else $error("point state not cleared while hunting");
    a_skip_no_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> !r_ch)
        else $error("half character pending during skip");
    a_sync_only_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.sync_error |-> r_phase == PH_HUNT)
        else $error("sync error outside hunting");
`endif

endmodule

>>> sv/range_reply_deframer_top.sv
// Range reply deframer: takes one byte of a scanner reply per word on i_byte and returns
// one word on o_dist per decoded distance (12-bit value, index, last flag) or a sync error
// word when no 'G' head is seen within sync_limit bytes. Each byte is decoded in the cycle it is taken;
// the result leaves through an output register backed by a one-word skid stage, so bytes
// keep flowing at one per cycle while a result waits, and i_byte stalls only when both are
// full. Config registers: 0 distance_count, 1 min_distance, 2 sync_limit; write only when
// no reply is in progress and no word is pending.
module range_reply_deframer_top
    import rrd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrd_byte_if.sink    i_byte,
    rrd_dist_if.source  o_dist,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    accept;
    logic    res_valid;
    t_result res;

    logic    r_out_valid, n_out_valid;
    t_result r_out, n_out;
    logic    r_skid_valid, n_skid_valid;
    t_result r_skid, n_skid;

    assign i_byte.ready = !r_skid_valid;
    assign accept       = i_byte.valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.distance_count <= RST_DISTANCE_COUNT;
            r_cfg.min_distance   <= RST_MIN_DISTANCE;
            r_cfg.sync_limit     <= RST_SYNC_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DISTANCE_COUNT: r_cfg.distance_count <= i_cfg_data[CNT_W-1:0];
                CFG_MIN_DISTANCE:   r_cfg.min_distance   <= i_cfg_data;
                CFG_SYNC_LIMIT:     r_cfg.sync_limit     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rrd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_byte.rx_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_out_valid && o_dist.ready) begin
            n_out_valid  = r_skid_valid;
            n_out        = r_skid;
            n_skid_valid = 1'b0;
        end
        if (res_valid) begin
            if (!n_out_valid) begin
                n_out_valid = 1'b1;
                n_out       = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_dist.valid       = r_out_valid;
    assign o_dist.distance    = r_out.distance;
    assign o_dist.point_index = r_out.point_index;
    assign o_dist.last        = r_out.last;
    assign o_dist.sync_error  = r_out.sync_error;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word without output word");
    a_skid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && o_dist.ready |=> r_out_valid && r_out == $past(r_skid))
        else $error("skid word lost on drain");
    a_sync_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.sync_error |->
            r_out.distance == '0 && r_out.point_index == '0 && !r_out.last)
        else $error("sync error word carries data");
`endif

endmodule

>>> verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rrd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int TOTAL_BYTES   = 1450;

    class deframe_scoreboard;
        t_result expected_words[$];

        logic [CNT_W-1:0]  count_reg;
        logic [DIST_W-1:0] min_dist;
        logic [POS_W-1:0]  sync_limit;

        logic [1:0]        phase;
        logic [POS_W-1:0]  byte_pos;
        logic [CNT_W-1:0]  point_cnt;
        logic [GP_W-1:0]   group_pos;
        logic [5:0]        high_char;
        logic              char_half;

        int errors;
        int n_dist;
        int n_last;
        int n_zeroed;
        int n_sync;

        function new();
            count_reg  = RST_DISTANCE_COUNT;
            min_dist   = RST_MIN_DISTANCE;
            sync_limit = RST_SYNC_LIMIT;
            restart(PH_HUNT);
        endfunction

        function void restart(logic [1:0] next_phase);
            phase     = next_phase;
            byte_pos  = '0;
            point_cnt = '0;
            group_pos = '0;
            high_char = '0;
            char_half = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [11:0] data);
            case (idx)
                CFG_DISTANCE_COUNT: count_reg = data[CNT_W-1:0];
                CFG_MIN_DISTANCE:   min_dist = data;
                CFG_SYNC_LIMIT:     sync_limit = data;
                default: ;
            endcase
        endfunction

        // one received byte in, zero or one expected word out
        function void take_byte(logic [7:0] b);
            int n;
            int reply_len;
            int grp_next;
            logic [5:0] six;
            logic [DIST_W-1:0] d;
            t_result w;
            n = (count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg);
            reply_len = int'(REPLY_OVERHEAD) + 2 * n + n / GROUP_SIZE;
            if (phase == PH_HUNT) begin
                if (b == HEAD_BYTE) begin
                    restart(PH_SKIP);
                end else if (byte_pos + 1 >= sync_limit) begin
                    byte_pos = '0;
                    w.distance = '0;
                    w.point_index = '0;
                    w.last = 1'b0;
                    w.sync_error = 1'b1;
                    expected_words.push_back(w);
                end else begin
                    byte_pos = byte_pos + 1'b1;
                end
                return;
            end
            case (phase)
                PH_SKIP: begin
                    if (byte_pos + 1 >= HEADER_SKIP)
                        phase = (point_cnt < n) ? PH_DATA : PH_TRAIL;
                end
                PH_DATA: begin
                    six = b[5:0] - CHAR_OFFSET;
                    if (point_cnt >= n) begin
                        phase = PH_TRAIL;
                    end else if (!char_half) begin
                        high_char = six;
                        char_half = 1'b1;
                    end else begin
                        d = {high_char, six};
                        if (d < min_dist)
                            d = '0;
                        char_half = 1'b0;
                        w.distance = d;
                        w.point_index = point_cnt;
                        w.last = (point_cnt + 1 == n);
                        w.sync_error = 1'b0;
                        expected_words.push_back(w);
                        point_cnt = point_cnt + 1'b1;
                        grp_next = group_pos + 1;
                        group_pos = grp_next[GP_W-1:0];
                        if (point_cnt >= n) begin
                            phase = PH_TRAIL;
                        end else if (grp_next >= GROUP_SIZE) begin
                            group_pos = '0;
                            phase = PH_SKIP;
                        end
                    end
                end
                default: ;
            endcase
            if (byte_pos + 1 >= reply_len)
                restart(PH_HUNT);
            else
                byte_pos = byte_pos + 1'b1;
        endfunction

        function void check_word(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: dist=%0d idx=%0d last=%0b err=%0b",
                             got.distance, got.point_index, got.last, got.sync_error);
                return;
            end
            want = expected_words.pop_front();
            if (got.distance !== want.distance || got.point_index !== want.point_index ||
                got.last !== want.last || got.sync_error !== want.sync_error) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch: exp dist=%0d idx=%0d last=%0b err=%0b, ",
                              "got dist=%0d idx=%0d last=%0b err=%0b"},
                             want.distance, want.point_index, want.last, want.sync_error,
                             got.distance, got.point_index, got.last, got.sync_error);
            end else if (want.sync_error) begin
                n_sync++;
            end else begin
                n_dist++;
                if (want.last)
                    n_last++;
                if (want.distance == 0)
                    n_zeroed++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [11:0] i_cfg_data;

    rrd_byte_if byte_if ();
    rrd_dist_if dist_if ();

    range_reply_deframer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_dist      (dist_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    deframe_scoreboard sb = new();

    int burst_left;
    int bytes_sent;
    int settings_used;
    int stall_cycle;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: stall pattern picked by bits 10:9 of stall_cycle: always ready, random, or periodic
    always @(posedge i_clk) begin
        t_result got;
        if (dist_if.valid && dist_if.ready) begin
            got.distance = dist_if.distance;
            got.point_index = dist_if.point_index;
            got.last = dist_if.last;
            got.sync_error = dist_if.sync_error;
            sb.check_word(got);
        end
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle >> 9) & 3)
            0: dist_if.ready <= i_rst_n;
            1: dist_if.ready <= i_rst_n && ($urandom_range(0, 3) != 0);
            2: dist_if.ready <= i_rst_n && ($urandom_range(0, 1) != 0);
            default: dist_if.ready <= i_rst_n && ((stall_cycle % 23) < 15);
        endcase
    end

    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                byte_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 24);
        end
        byte_if.valid <= 1'b1;
        byte_if.rx_byte <= b;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        sb.take_byte(b);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic push_pair(input logic [11:0] d);
        logic [7:0] c0;
        logic [7:0] c1;
        c0 = 8'h30 + {2'b00, d[11:6]};
        c1 = 8'h30 + {2'b00, d[5:0]};
        if ($urandom_range(0, 9) == 0)
            c0 = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0)
            c1 = 8'($urandom_range(0, 255));
        push_byte(c0);
        push_byte(c1);
    endtask

    function automatic logic [11:0] pick_distance();
        case ($urandom_range(0, 7))
            0: return sb.min_dist;
            1: return sb.min_dist - 1'b1;
            2: return 12'd0;
            3: return 12'hFFF;
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // head, header, n distances with separators, trailer; len_adjust breaks the framing
    task automatic send_reply(input int n, input int len_adjust);
        int sent;
        int total;
        push_byte(HEAD_BYTE);
        repeat (int'(HEADER_SKIP)) push_byte(8'($urandom_range(0, 255)));
        sent = int'(HEADER_SKIP);
        for (int i = 0; i < n; i++) begin
            if (i > 0 && i % GROUP_SIZE == 0) begin
                push_byte(8'($urandom_range(0, 255)));
                sent++;
            end
            push_pair(pick_distance());
            sent += 2;
        end
        total = int'(REPLY_OVERHEAD) + 2 * n + n / GROUP_SIZE + len_adjust;
        while (sent < total) begin
            push_byte(8'($urandom_range(0, 255)));
            sent++;
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic finish_reply();
        while (sb.phase != PH_HUNT) push_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        byte_if.valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [9:0] dc, input logic [11:0] md,
                              input logic [11:0] sl);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_DISTANCE_COUNT;
        i_cfg_data <= {2'b00, dc};
        @(posedge i_clk);
        sb.set_reg(CFG_DISTANCE_COUNT, {2'b00, dc});
        i_cfg_index <= CFG_MIN_DISTANCE;
        i_cfg_data <= md;
        @(posedge i_clk);
        sb.set_reg(CFG_MIN_DISTANCE, md);
        i_cfg_index <= CFG_SYNC_LIMIT;
        i_cfg_data <= sl;
        @(posedge i_clk);
        sb.set_reg(CFG_SYNC_LIMIT, sl);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        int segments;
        logic [9:0]  dc;
        logic [11:0] md;
        logic [11:0] sl;

        i_rst_n <= 1'b0;
        byte_if.valid <= 1'b0;
        byte_if.rx_byte <= 8'h00;
        i_cfg_we <= 1'b0;
        i_cfg_index <= CFG_DISTANCE_COUNT;
        i_cfg_data <= 12'h000;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: head on the limit byte, char extremes, sync error
        write_regs(10'd3, 12'd20, 12'd4);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h41);
        push_byte(HEAD_BYTE);
        for (int i = 0; i < int'(HEADER_SKIP); i++)
            push_byte((i % 3 == 0) ? HEAD_BYTE : (i % 3 == 1) ? 8'hFF : 8'h00);
        push_byte(8'h30);
        push_byte(8'h30);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h6F);
        push_byte(8'h6F);
        repeat (4) push_byte(8'h0D);
        repeat (4) push_byte(8'h78);
        settle();

        // zero distances, zero sync limit
        write_regs(10'd0, 12'd0, 12'd0);
        send_noise(3);
        send_reply(0, 0);
        push_byte(8'h00);
        push_byte(8'hFF);
        settle();

        // one distance, top minimum, limit of one
        write_regs(10'd1, 12'hFFF, 12'd1);
        push_byte(HEAD_BYTE);
        repeat (int'(HEADER_SKIP)) push_byte(8'h20);
        push_byte(8'h6F);
        push_byte(8'h6F);
        repeat (4) push_byte(8'h0A);
        push_byte(HEAD_BYTE);
        repeat (int'(HEADER_SKIP)) push_byte(8'h20);
        push_byte(8'h6F);
        push_byte(8'h6E);
        repeat (4) push_byte(8'h0A);
        send_noise(3);
        settle();

        // long scan over ten groups
        write_regs(10'd300, 12'd0, 12'hFFF);
        send_reply(300, 0);
        finish_reply();
        send_noise(10);
        settle();

        while (bytes_sent < TOTAL_BYTES) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: dc = 10'($urandom_range(1, 40));
                7, 8: dc = 10'($urandom_range(33, 100));
                default: dc = 10'($urandom_range(0, 3));
            endcase
            case ($urandom_range(0, 3))
                0: md = 12'd0;
                1: md = 12'($urandom_range(0, 4095));
                2: md = 12'($urandom_range(0, 200));
                default: md = 12'hFFF;
            endcase
            case ($urandom_range(0, 4))
                0: sl = 12'($urandom_range(0, 2));
                1: sl = 12'($urandom_range(100, 4095));
                default: sl = 12'($urandom_range(1, 40));
            endcase
            write_regs(dc, md, sl);
            segments = $urandom_range(3, 8);
            repeat (segments) begin
                if (bytes_sent < TOTAL_BYTES) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5, 6:
                            send_reply(int'(sb.count_reg),
                                       ($urandom_range(0, 5) == 0) ?
                                           int'($urandom_range(0, 6)) - 3 : 0);
                        7, 8: send_noise($urandom_range(1, 30));
                        default: settle();
                    endcase
                end
            end
            finish_reply();
            settle();
        end

        byte_if.valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d bytes over %0d register settings: %0d distance words (%0d last, %0d zeroed)",
                 bytes_sent, settings_used, sb.n_dist, sb.n_last, sb.n_zeroed);
        $display("%0d sync error words, %0d mismatches", sb.n_sync, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

>>> sim.f
sv/rrd_pkg.sv
sv/rrd_byte_if.sv
sv/rrd_dist_if.sv
sv/rrd_core.sv
sv/range_reply_deframer_top.sv
verif/tb_top.sv
